>>> rtl/gh_pkg.sv
// ----------------------------------------------------------------------------
// gh_pkg
// Shared types, codes and the GF(2^128) multiply for the GHASH accumulator.
// ----------------------------------------------------------------------------
package gh_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int COUNT_W = 5;

    // reduction byte for x^128 + x^7 + x^2 + x + 1, reflected order
    localparam logic [7:0] REDUCE_BYTE = 8'hE1;
    localparam logic [COUNT_W-1:0] FULL_BLOCK_BYTES = 5'd16;

    typedef enum logic [1:0] {
        KIND_AAD    = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef enum logic {
        REG_SUBKEY_HIGH = 1'b0,
        REG_SUBKEY_LOW  = 1'b1
    } reg_index_t;

    // z = x * h, GCM bit order: x[127] is the coefficient of x^0
    function automatic logic [BLOCK_W-1:0] gf_mul(input logic [BLOCK_W-1:0] x,
                                                   input logic [BLOCK_W-1:0] h);
        logic [BLOCK_W-1:0] z;
        logic [BLOCK_W-1:0] v;
        z = '0;
        v = h;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            if (x[BLOCK_W-1-i])
            begin
                z = z ^ v;
            end
            if (v[0])
            begin
                v = (v >> 1) ^ {REDUCE_BYTE, {(BLOCK_W-8){1'b0}}};
            end
            else
            begin
                v = v >> 1;
            end
        end
        return z;
    endfunction

endpackage

>>> rtl/ghash_accumulator.sv
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH engine: blocks are masked, folded into the accumulator and
// multiplied by the subkey H; a finish transaction folds in the length block.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: block, count; tuser: kind
//  m_*       out  m_tvalid/m_tready    tdata: hash
//  apb       in   psel/penable/pready  subkey_high @0x0, subkey_low @0x8
//
//  One transaction per cycle unless a finish waits: an input register
//  feeds a single combinational GF(2^128) multiply whose result lands in
//  the accumulator (or the output register on finish) at the next edge.
//  Reset clears accumulator, lengths, subkey and all valid flags.
//  A finish waits in the input register only while the output register is
//  full and not being taken; data blocks never wait.
// ----------------------------------------------------------------------------
module ghash_accumulator
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // block_high[63:0], block_low[127:64],
                                    // byte_count[132:128], zero pad
    input  logic [1:0]   s_tuser,   // kind[1:0]

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // hash_high[63:0], hash_low[127:64]

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [gh_pkg::HALF_W-1:0]  subkey_high_reg;
    logic [gh_pkg::HALF_W-1:0]  subkey_low_reg;

    logic                       in_valid_reg;
    gh_pkg::kind_t              in_kind_reg;
    logic [gh_pkg::BLOCK_W-1:0] in_block_reg;
    logic [gh_pkg::COUNT_W-1:0] in_count_reg;

    logic [gh_pkg::BLOCK_W-1:0] acc_reg;
    logic [gh_pkg::BLOCK_W-1:0] acc_next;
    logic [gh_pkg::HALF_W-1:0]  aad_len_reg;
    logic [gh_pkg::HALF_W-1:0]  aad_len_next;
    logic [gh_pkg::HALF_W-1:0]  text_len_reg;
    logic [gh_pkg::HALF_W-1:0]  text_len_next;

    logic                       out_valid_reg;
    logic [gh_pkg::BLOCK_W-1:0] out_data_reg;

    logic                       in_drain;
    logic                       is_finish;
    logic [gh_pkg::COUNT_W-1:0] count_sat;
    logic [7:0]                 mask_shift;
    logic [gh_pkg::BLOCK_W-1:0] block_mask;
    logic [gh_pkg::BLOCK_W-1:0] mul_in;
    logic [gh_pkg::BLOCK_W-1:0] product;
    logic [gh_pkg::HALF_W-1:0]  bit_len;
    logic                       cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (gh_pkg::reg_index_t'(paddr[3]) == gh_pkg::REG_SUBKEY_LOW)
                     ? subkey_low_reg : subkey_high_reg;

    // ---------------- datapath ----------------
    assign is_finish = (in_kind_reg == gh_pkg::KIND_FINISH);
    assign in_drain  = in_valid_reg && (!is_finish || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || in_drain;

    assign count_sat  = (in_count_reg > gh_pkg::FULL_BLOCK_BYTES)
                      ? gh_pkg::FULL_BLOCK_BYTES : in_count_reg;
    // a zero count shifts by 128 and clears the mask, but its product is never stored
    assign mask_shift = {gh_pkg::FULL_BLOCK_BYTES - count_sat, 3'b000};
    assign block_mask = {gh_pkg::BLOCK_W{1'b1}} << mask_shift;
    assign bit_len    = {{(gh_pkg::HALF_W-8){1'b0}}, count_sat, 3'b000};

    assign mul_in  = is_finish ? (acc_reg ^ {aad_len_reg, text_len_reg})
                               : (acc_reg ^ (in_block_reg & block_mask));
    assign product = gh_pkg::gf_mul(mul_in, {subkey_high_reg, subkey_low_reg});

    always_comb
    begin
        acc_next      = acc_reg;
        aad_len_next  = aad_len_reg;
        text_len_next = text_len_reg;
        if (in_drain)
        begin
            case (in_kind_reg)
                gh_pkg::KIND_AAD:
                begin
                    if (in_count_reg != '0)
                    begin
                        acc_next     = product;
                        aad_len_next = aad_len_reg + bit_len;
                    end
                end
                gh_pkg::KIND_TEXT:
                begin
                    if (in_count_reg != '0)
                    begin
                        acc_next      = product;
                        text_len_next = text_len_reg + bit_len;
                    end
                end
                gh_pkg::KIND_FINISH:
                begin
                    acc_next      = '0;
                    aad_len_next  = '0;
                    text_len_next = '0;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subkey_high_reg <= '0;
            subkey_low_reg  <= '0;
            in_valid_reg    <= 1'b0;
            acc_reg         <= '0;
            aad_len_reg     <= '0;
            text_len_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (gh_pkg::reg_index_t'(paddr[3]) == gh_pkg::REG_SUBKEY_LOW)
                begin
                    subkey_low_reg <= pwdata;
                end
                else
                begin
                    subkey_high_reg <= pwdata;
                end
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            acc_reg      <= acc_next;
            aad_len_reg  <= aad_len_next;
            text_len_reg <= text_len_next;
            if (in_drain && is_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg  <= gh_pkg::kind_t'(s_tuser);
            in_block_reg <= {s_tdata[63:0], s_tdata[127:64]};
            in_count_reg <= s_tdata[132:128];
        end
        if (in_drain && is_finish)
        begin
            out_data_reg <= product;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[63:0], out_data_reg[127:64]};

    // ---------------- assertions ----------------
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_drain && is_finish) |=> m_tvalid)
        else $error("finish did not load the output register");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_drain && is_finish) |=> (acc_reg == '0 && aad_len_reg == '0
                                     && text_len_reg == '0))
        else $error("state not cleared after finish");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && is_finish && out_valid_reg && !m_tready) |-> !in_drain)
        else $error("finish overwrote a pending result");

    a_empty_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_drain && !is_finish && in_count_reg == '0)
        |=> ($stable(acc_reg) && $stable(aad_len_reg) && $stable(text_len_reg)))
        else $error("empty block changed the state");

endmodule

>>> bench/tb_ghash_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ghash_accumulator
// Self-checking bench for the GHASH accumulator. Directed blocks cover full,
// partial, empty and oversized blocks, the unused kind, AAD after ciphertext
// and an empty finish. Random messages follow under several subkeys, with
// random gaps on both streams, zero-gap stretches and one long output stall.
// Hashes are predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
module tb_ghash_accumulator;

    localparam logic [1:0]   KIND_RESERVED = 2'd3;
    localparam logic [127:0] GF_FOLD       = {gh_pkg::REDUCE_BYTE, 120'd0};
    localparam int           STALL_LIMIT   = 4000;
    localparam int           HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
    } gh_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // block_high[63:0], block_low[127:64],
                             // byte_count[132:128], zero pad
    logic [1:0]   s_tuser;   // kind[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // hash_high[63:0], hash_low[127:64]
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    ghash_accumulator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // bench copy of the block state
    logic [127:0] subkey_copy;
    logic [127:0] running_hash;
    logic [63:0]  aad_bit_sum;
    logic [63:0]  text_bits;

    gh_item_t     pending_blocks[$];
    logic [127:0] hash_expect[$];   // {hash_high, hash_low}

    gh_item_t next_item;
    logic     in_taken;
    logic     out_taken;
    logic     burst_mode;
    logic     rx_hold;
    int       send_gap;
    int       rx_wait;
    int       rx_draw;
    int       stall_cycles;
    int       fail_count;
    int       items_sent;
    int       blocks_hashed;
    int       ignored_items;
    int       hashes_checked;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // multiply by H, Horner form from the highest-degree coefficient down
    function automatic logic [127:0] times_subkey(input logic [127:0] x);
        logic [127:0] prod;
        prod = '0;
        for (int d = 127; d >= 0; d--)
        begin
            prod = prod[0] ? ((prod >> 1) ^ GF_FOLD) : (prod >> 1);
            if (x[127 - d])
            begin
                prod = prod ^ subkey_copy;
            end
        end
        return prod;
    endfunction

    task automatic absorb_transaction(input logic [1:0] kind, input logic [135:0] data);
        logic [127:0] block;
        logic [4:0]   count;
        int           nbytes;
        block  = {data[63:0], data[127:64]};
        count  = data[132:128];
        nbytes = (count > gh_pkg::FULL_BLOCK_BYTES) ? 16 : int'(count);
        items_sent++;
        case (kind)
            gh_pkg::KIND_AAD, gh_pkg::KIND_TEXT:
            begin
                if (nbytes == 0)
                begin
                    ignored_items++;
                end
                else
                begin
                    block = block & (~128'd0 << (8 * (16 - nbytes)));
                    running_hash = times_subkey(running_hash ^ block);
                    if (kind == gh_pkg::KIND_AAD)
                    begin
                        aad_bit_sum = aad_bit_sum + 64'(8 * nbytes);
                    end
                    else
                    begin
                        text_bits = text_bits + 64'(8 * nbytes);
                    end
                    blocks_hashed++;
                end
            end
            gh_pkg::KIND_FINISH:
            begin
                hash_expect.push_back(times_subkey(running_hash ^ {aad_bit_sum, text_bits}));
                running_hash = '0;
                aad_bit_sum  = '0;
                text_bits    = '0;
            end
            default:
            begin
                ignored_items++;
            end
        endcase
    endtask

    task automatic check_hash(input logic [127:0] data);
        logic [127:0] want;
        if (hash_expect.size() == 0)
        begin
            $display("%0t: hash with none expected, got %h", $time, data);
            fail_count++;
        end
        else
        begin
            want = hash_expect.pop_front();
            if (data[63:0] !== want[127:64])
            begin
                $display("%0t: hash_high expected %h got %h", $time, want[127:64], data[63:0]);
                fail_count++;
            end
            if (data[127:64] !== want[63:0])
            begin
                $display("%0t: hash_low expected %h got %h", $time, want[63:0], data[127:64]);
                fail_count++;
            end
            hashes_checked++;
        end
    endtask

    // monitor and watchdog
    always @(posedge clk)
    begin
        in_taken  <= s_tvalid && s_tready;
        out_taken <= m_tvalid && m_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            absorb_transaction(s_tuser, s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            check_hash(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_blocks.size() != 0)
            begin
                next_item = pending_blocks.pop_front();
                s_tdata  <= {3'd0, next_item.byte_count, next_item.block_low,
                             next_item.block_high};
                s_tuser  <= next_item.kind;
                s_tvalid <= 1'b1;
                send_gap <= burst_mode ? 0 : $urandom_range(0, 13);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output receiver
    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
        begin
            m_tready <= 1'b0;
        end
        else if (out_taken)
        begin
            rx_draw = burst_mode ? 0 : $urandom_range(0, 13);
            rx_wait  <= rx_draw;
            m_tready <= (rx_draw == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_subkey(input gh_pkg::reg_index_t idx, input logic [63:0] value);
        logic [63:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 3;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == gh_pkg::REG_SUBKEY_HIGH)
        begin
            subkey_copy[127:64] = value;
        end
        else
        begin
            subkey_copy[63:0] = value;
        end
        // read back through the same port
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
        begin
            $display("%0t: subkey register %0d expected %h got %h", $time, idx, value,
                     readback);
            fail_count++;
        end
    endtask

    task automatic set_subkey(input logic [63:0] high, input logic [63:0] low);
        write_subkey(gh_pkg::REG_SUBKEY_HIGH, high);
        write_subkey(gh_pkg::REG_SUBKEY_LOW, low);
    endtask

    task automatic queue_item(input logic [1:0] kind, input logic [63:0] high,
                              input logic [63:0] low, input logic [4:0] count);
        gh_item_t item;
        item.kind       = kind;
        item.block_high = high;
        item.block_low  = low;
        item.byte_count = count;
        pending_blocks.push_back(item);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [4:0] tail_count();
        return ($urandom_range(0, 2) == 0) ? 5'($urandom_range(1, 16))
                                           : gh_pkg::FULL_BLOCK_BYTES;
    endfunction

    task automatic queue_noise();
        case ($urandom_range(0, 3))
            0: queue_item(KIND_RESERVED, rand64(), rand64(), 5'($urandom));
            1: queue_item(2'($urandom_range(0, 1)), rand64(), rand64(), 5'd0);
            2: queue_item(2'($urandom_range(0, 1)), rand64(), rand64(),
                          5'($urandom_range(17, 31)));
            default: queue_item(gh_pkg::KIND_AAD, rand64(), rand64(), tail_count());
        endcase
    endtask

    // AAD then ciphertext, last chunk of each possibly short, sometimes a noise item, then finish
    task automatic queue_message(input int max_aad, input int max_text);
        int aad_n;
        int text_n;
        aad_n  = $urandom_range(0, max_aad);
        text_n = $urandom_range(0, max_text);
        for (int i = 0; i < aad_n; i++)
        begin
            queue_item(gh_pkg::KIND_AAD, rand64(), rand64(),
                       (i == aad_n - 1) ? tail_count() : gh_pkg::FULL_BLOCK_BYTES);
        end
        for (int i = 0; i < text_n; i++)
        begin
            queue_item(gh_pkg::KIND_TEXT, rand64(), rand64(),
                       (i == text_n - 1) ? tail_count() : gh_pkg::FULL_BLOCK_BYTES);
        end
        if ($urandom_range(0, 5) == 0)
        begin
            queue_noise();
        end
        queue_item(gh_pkg::KIND_FINISH, rand64(), rand64(), 5'($urandom));
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_blocks.size() != 0 || s_tvalid || hash_expect.size() != 0);
        // blocks in flight give no result; let the pipe settle
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_taken       = 1'b0;
        out_taken      = 1'b0;
        burst_mode     = 1'b0;
        rx_hold        = 1'b0;
        send_gap       = 0;
        rx_wait        = 0;
        stall_cycles   = 0;
        fail_count     = 0;
        items_sent     = 0;
        blocks_hashed  = 0;
        ignored_items  = 0;
        hashes_checked = 0;
        subkey_copy    = '0;
        running_hash   = '0;
        aad_bit_sum    = '0;
        text_bits      = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and corner cases
        set_subkey(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
        @(posedge clk);
        queue_item(gh_pkg::KIND_FINISH, '0, '0, gh_pkg::FULL_BLOCK_BYTES);  // empty message
        queue_item(gh_pkg::KIND_AAD, '1, '1, gh_pkg::FULL_BLOCK_BYTES);
        queue_item(gh_pkg::KIND_AAD, '1, '1, 5'd1);
        queue_item(gh_pkg::KIND_TEXT, rand64(), rand64(), 5'd8);
        queue_item(gh_pkg::KIND_TEXT, '1, '1, 5'd9);
        queue_item(gh_pkg::KIND_TEXT, rand64(), rand64(), 5'd15);
        queue_item(gh_pkg::KIND_AAD, '1, '1, 5'd0);                  // empty chunks
        queue_item(gh_pkg::KIND_TEXT, '1, '1, 5'd0);
        queue_item(KIND_RESERVED, '1, '1, 5'd31);
        queue_item(gh_pkg::KIND_FINISH, '1, '1, 5'd31);
        queue_item(gh_pkg::KIND_TEXT, '1, '1, 5'd17);                // count saturates
        queue_item(gh_pkg::KIND_AAD, rand64(), rand64(), 5'd31);
        queue_item(gh_pkg::KIND_TEXT, '0, '0, gh_pkg::FULL_BLOCK_BYTES);
        queue_item(gh_pkg::KIND_AAD, rand64(), rand64(), 5'd3);      // AAD after ciphertext
        queue_item(gh_pkg::KIND_FINISH, '0, '0, 5'd0);
        queue_item(gh_pkg::KIND_AAD, '0, '0, gh_pkg::FULL_BLOCK_BYTES);
        queue_item(gh_pkg::KIND_FINISH, rand64(), rand64(), 5'd1);
        wait_idle();

        // random messages under zero, all-ones, unity and random subkeys
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_subkey('0, '0);
                1: set_subkey('1, '1);
                2: set_subkey(64'h8000_0000_0000_0000, '0);
                default: set_subkey(rand64(), rand64());
            endcase
            for (int half = 0; half < 2; half++)
            begin
                @(posedge clk);
                burst_mode <= (half == phase % 2);
                for (int m = 0; m < 16; m++)
                begin
                    queue_message(4, 6);
                end
                wait_idle();
            end
        end

        // short messages of at most one AAD and one text block against a stalled output
        set_subkey(rand64(), rand64());
        @(posedge clk);
        burst_mode <= 1'b1;
        for (int m = 0; m < 24; m++)
        begin
            queue_message(1, 1);
        end
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
        wait_idle();

        $display("Accepted %0d input transactions: %0d blocks hashed, %0d ignored.",
                 items_sent, blocks_hashed, ignored_items);
        $display("Checked %0d hashes under six subkey settings.", hashes_checked);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/gh_pkg.sv
rtl/ghash_accumulator.sv
bench/tb_ghash_accumulator.sv
